@@ hdl/slc_pkg.sv @@
// ----------------------------------------------------------------------------
// slc_pkg: shared definitions for the sequential list engine
// Sizes, operation and status codes, cell control type.
// ----------------------------------------------------------------------------
package slc_pkg;

    localparam int CAPACITY      = 16;
    localparam int ELEMENT_WIDTH = 32;
    localparam int IDX_W         = $clog2(CAPACITY);

    // fixed field widths of the stream payload
    localparam int OP_W    = 2;
    localparam int POS_W   = 5;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    // operation codes
    localparam logic [OP_W-1:0] OP_RETRIEVE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOCATE   = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE   = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // cell modes
    typedef logic [1:0] cell_mode_t;
    localparam cell_mode_t CELL_HOLD       = 2'd0;
    localparam cell_mode_t CELL_LOAD       = 2'd1;
    localparam cell_mode_t CELL_TAKE_LOWER = 2'd2;
    localparam cell_mode_t CELL_TAKE_UPPER = 2'd3;

    typedef struct packed {
        cell_mode_t mode;
        logic       capture;   // register compare result
    } cell_ctl_t;

endpackage

@@ hdl/slc_cell.sv @@
// ----------------------------------------------------------------------------
// slc_cell: one list entry
// Holds a value, takes it from either neighbor or loads a new one,
// and registers an equality compare against the search key.
// ----------------------------------------------------------------------------
module slc_cell (
    input  logic                                aclk,
    input  slc_pkg::cell_ctl_t                  ctl,
    input  logic [slc_pkg::ELEMENT_WIDTH-1:0]   load_data,
    input  logic [slc_pkg::ELEMENT_WIDTH-1:0]   lower_data,
    input  logic [slc_pkg::ELEMENT_WIDTH-1:0]   upper_data,
    input  logic [slc_pkg::ELEMENT_WIDTH-1:0]   key,
    output logic [slc_pkg::ELEMENT_WIDTH-1:0]   data_out,
    output logic                                match_out
);

    logic [slc_pkg::ELEMENT_WIDTH-1:0] data_reg;
    logic [slc_pkg::ELEMENT_WIDTH-1:0] data_next;
    logic                              match_reg;

    always_comb begin
        unique case (ctl.mode)
            slc_pkg::CELL_LOAD:       data_next = load_data;
            slc_pkg::CELL_TAKE_LOWER: data_next = lower_data;
            slc_pkg::CELL_TAKE_UPPER: data_next = upper_data;
            default:                  data_next = data_reg;
        endcase
    end

    // compare uses the contents before this cycle's move
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (ctl.capture) begin
            match_reg <= (data_reg == key);
        end
    end

    assign data_out  = data_reg;
    assign match_out = match_reg;

endmodule

@@ hdl/sequential_list_engine.sv @@
// ----------------------------------------------------------------------------
// sequential_list_engine: ordered list with retrieve, locate, insert, delete
// Position-addressed list held in a row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on s_tvalid/s_tready/s_tdata and carry an
//   operation, a 1-based position and a value. Each one yields exactly one
//   result transaction on m_tvalid/m_tready/m_tdata with status, the value
//   read by retrieve, the position found by locate and the new length.
//   Sequence: in the accept cycle the range checks are decided and every
//   cell shifts, loads or holds at once while registering its compare
//   against the key; in state S_FIN the match bits go through a priority
//   encoder and the result register is loaded once it is free. Only then
//   does the engine return to idle and accept the next item, so it never
//   takes a new item before the last one has reached the result register.
//   Stalls: the result register keeps its transaction until m_tready. A
//   new item may be accepted while a result waits; the engine then holds
//   its second step until the result register frees up.
//   Reset (aresetn low, synchronous) empties the list and drops any pending
//   result. Entry contents are not cleared; only entries below the length
//   are ever read.
// ----------------------------------------------------------------------------
module sequential_list_engine (
    input  logic                             aclk,
    input  logic                             aresetn,
    // fields from bit 0: operation[1:0], position[6:2], value[38:7], zero pad
    input  logic [slc_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fields from bit 0: status[1:0], value_out[33:2], position_out[38:34],
    // length_out[43:39], zero pad
    output logic [slc_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready
);

    localparam int CAP = slc_pkg::CAPACITY;
    localparam int EW  = slc_pkg::ELEMENT_WIDTH;

    // state codes
    localparam logic S_IDLE = 1'b0;
    localparam logic S_FIN  = 1'b1;

    logic state_reg, state_next;

    // input fields
    logic [slc_pkg::OP_W-1:0]  in_op;
    logic [slc_pkg::POS_W-1:0] in_pos;
    logic [slc_pkg::VAL_W-1:0] in_val;
    logic [EW-1:0]             in_key;
    assign in_op  = s_tdata[1:0];
    assign in_pos = s_tdata[6:2];
    assign in_val = s_tdata[38:7];
    assign in_key = in_val[EW-1:0];

    logic s_fire;
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // list length and captured item data
    logic [slc_pkg::LEN_W-1:0]  fill_reg, fill_next;
    logic [slc_pkg::OP_W-1:0]   op_reg;
    logic [slc_pkg::STAT_W-1:0] status_reg, status_next;
    logic [EW-1:0]              rdata_reg, rdata_next;

    // position checks against the current length
    logic [slc_pkg::POS_W-1:0] k;        // 0-based index
    logic                      pos_nz;
    logic                      rd_ok;    // 1..length
    logic                      ins_ok;   // 1..length+1
    logic                      full;
    logic                      do_ins;
    logic                      do_del;

    assign k      = in_pos - slc_pkg::POS_W'(1);
    assign pos_nz = (in_pos != '0);
    assign rd_ok  = pos_nz && (in_pos <= fill_reg);
    assign ins_ok = pos_nz && (in_pos <= fill_reg + slc_pkg::LEN_W'(1));
    assign full   = (fill_reg == slc_pkg::LEN_W'(CAP));
    assign do_ins = s_fire && (in_op == slc_pkg::OP_INSERT) && ins_ok && !full;
    assign do_del = s_fire && (in_op == slc_pkg::OP_DELETE) && rd_ok;

    // cell row
    slc_pkg::cell_ctl_t cell_ctl  [CAP];
    logic [EW-1:0]      cell_data [CAP];
    logic [CAP-1:0]     cell_match;

    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            cell_ctl[i].capture = s_fire;
            cell_ctl[i].mode    = slc_pkg::CELL_HOLD;
            if (do_ins) begin
                if (slc_pkg::POS_W'(i) == k) begin
                    cell_ctl[i].mode = slc_pkg::CELL_LOAD;
                end else if (slc_pkg::POS_W'(i) > k &&
                             slc_pkg::POS_W'(i) <= fill_reg) begin
                    cell_ctl[i].mode = slc_pkg::CELL_TAKE_LOWER;
                end
            end else if (do_del) begin
                // entries from k up to length-2 pull from above
                if (slc_pkg::POS_W'(i) >= k &&
                    slc_pkg::POS_W'(i) + slc_pkg::POS_W'(1) < fill_reg) begin
                    cell_ctl[i].mode = slc_pkg::CELL_TAKE_UPPER;
                end
            end
        end
    end

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        logic [EW-1:0] lower_w;
        logic [EW-1:0] upper_w;
        if (g == 0) begin : g_first
            assign lower_w = '0;
        end else begin : g_mid_lo
            assign lower_w = cell_data[g-1];
        end
        if (g == CAP-1) begin : g_last
            assign upper_w = '0;
        end else begin : g_mid_hi
            assign upper_w = cell_data[g+1];
        end
        slc_cell u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl[g]),
            .load_data  (in_key),
            .lower_data (lower_w),
            .upper_data (upper_w),
            .key        (in_key),
            .data_out   (cell_data[g]),
            .match_out  (cell_match[g])
        );
    end

    // accept-cycle decisions
    always_comb begin
        fill_next   = fill_reg;
        status_next = slc_pkg::ST_RANGE;
        rdata_next  = '0;
        if (s_fire) begin
            unique case (in_op)
                slc_pkg::OP_RETRIEVE: begin
                    if (rd_ok) begin
                        status_next = slc_pkg::ST_OK;
                        rdata_next  = cell_data[k[slc_pkg::IDX_W-1:0]];
                    end
                end
                slc_pkg::OP_INSERT: begin
                    if (ins_ok) begin
                        if (full) begin
                            status_next = slc_pkg::ST_FULL;
                        end else begin
                            status_next = slc_pkg::ST_OK;
                            fill_next   = fill_reg + slc_pkg::LEN_W'(1);
                        end
                    end
                end
                slc_pkg::OP_DELETE: begin
                    if (rd_ok) begin
                        status_next = slc_pkg::ST_OK;
                        fill_next   = fill_reg - slc_pkg::LEN_W'(1);
                    end
                end
                default: begin
                    // locate: settled in state S_FIN
                    status_next = slc_pkg::ST_RANGE;
                end
            endcase
        end
    end

    // locate: lowest live entry that matched
    logic                      loc_hit;
    logic [slc_pkg::POS_W-1:0] loc_pos;

    always_comb begin
        loc_hit = 1'b0;
        loc_pos = '0;
        for (int i = CAP-1; i >= 0; i--) begin
            if (cell_match[i] && (slc_pkg::LEN_W'(i) < fill_reg)) begin
                loc_hit = 1'b1;
                loc_pos = slc_pkg::POS_W'(i + 1);
            end
        end
    end

    // result register
    logic                       out_load;
    logic [slc_pkg::STAT_W-1:0] res_status;
    logic [slc_pkg::POS_W-1:0]  res_pos;
    logic [slc_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                       m_tvalid_reg, m_tvalid_next;

    assign out_load = (state_reg == S_FIN) && (!m_tvalid_reg || m_tready);

    always_comb begin
        if (op_reg == slc_pkg::OP_LOCATE) begin
            res_status = loc_hit ? slc_pkg::ST_OK : slc_pkg::ST_RANGE;
            res_pos    = loc_pos;
        end else begin
            res_status = status_reg;
            res_pos    = '0;
        end
        m_tdata_next = {4'b0000, fill_reg, res_pos, slc_pkg::VAL_W'(rdata_reg), res_status};
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_fire) state_next = S_FIN;
            default: if (out_load) state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg     <= in_op;
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
        end
        if (out_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= slc_pkg::LEN_W'(CAP))
        else $error("list length above capacity");

    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] == slc_pkg::ST_FULL)
            |-> (m_tdata[43:39] == slc_pkg::LEN_W'(CAP)))
        else $error("full status with list not full");

    a_pos_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[38:34] != '0) |-> (m_tdata[1:0] == slc_pkg::ST_OK))
        else $error("position reported on failed operation");

    a_val_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[33:2] != '0) |-> (m_tdata[1:0] == slc_pkg::ST_OK))
        else $error("value reported on failed operation");
`endif

endmodule

@@ tb/tb_sequential_list_engine.sv @@
// ----------------------------------------------------------------------------
// tb_sequential_list_engine: self-checking bench for the sequential list engine
// Drives retrieve/locate/insert/delete transactions with random gaps and
// output back-pressure, predicts every result from a shadow copy of the list
// and compares each result transaction field by field in order.
// ----------------------------------------------------------------------------

// one predicted or observed result transaction
typedef struct packed {
    logic [slc_pkg::STAT_W-1:0] status;
    logic [slc_pkg::VAL_W-1:0]  value_out;
    logic [slc_pkg::POS_W-1:0]  position_out;
    logic [slc_pkg::LEN_W-1:0]  length_out;
} list_result_t;

// shadow list plus the queue of results still owed by the engine
class list_scoreboard;
    logic [slc_pkg::ELEMENT_WIDTH-1:0] cells [slc_pkg::CAPACITY];
    int                                length;
    list_result_t                      owed_q[$];
    int                                errors;

    function new();
        length = 0;
        errors = 0;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40)
            $display("mismatch at %0t: %s", $time, msg);
    endtask

    // apply one accepted input to the shadow list and queue its result
    function void note_input(logic [slc_pkg::OP_W-1:0] op, logic [slc_pkg::POS_W-1:0] pos,
                             logic [slc_pkg::VAL_W-1:0] val);
        list_result_t r;
        int           p;
        int           i;
        logic [slc_pkg::ELEMENT_WIDTH-1:0] key;
        r = '0;
        r.status = slc_pkg::ST_RANGE;
        p = int'(pos);
        key = val[slc_pkg::ELEMENT_WIDTH-1:0];
        case (op)
            slc_pkg::OP_RETRIEVE: begin
                if (p >= 1 && p <= length) begin
                    r.value_out = slc_pkg::VAL_W'(cells[p-1]);
                    r.status    = slc_pkg::ST_OK;
                end
            end
            slc_pkg::OP_LOCATE: begin
                for (i = 0; i < length; i++) begin
                    if (r.status != slc_pkg::ST_OK && cells[i] == key) begin
                        r.position_out = slc_pkg::POS_W'(i + 1);
                        r.status       = slc_pkg::ST_OK;
                    end
                end
            end
            slc_pkg::OP_INSERT: begin
                if (p >= 1 && p <= length + 1) begin
                    if (length >= slc_pkg::CAPACITY) begin
                        r.status = slc_pkg::ST_FULL;
                    end else begin
                        for (i = length; i >= p; i--)
                            cells[i] = cells[i-1];
                        cells[p-1] = key;
                        length++;
                        r.status = slc_pkg::ST_OK;
                    end
                end
            end
            default: begin
                if (p >= 1 && p <= length) begin
                    for (i = p; i < length; i++)
                        cells[i-1] = cells[i];
                    length--;
                    r.status = slc_pkg::ST_OK;
                end
            end
        endcase
        r.length_out = slc_pkg::LEN_W'(length);
        owed_q.push_back(r);
    endfunction

    // compare one result transaction against the oldest owed result
    task check_result(logic [slc_pkg::M_DATA_W-1:0] d);
        list_result_t got;
        list_result_t want;
        got.status       = d[1:0];
        got.value_out    = d[33:2];
        got.position_out = d[38:34];
        got.length_out   = d[43:39];
        if (owed_q.size() == 0) begin
            report("result transaction with nothing outstanding");
        end else begin
            want = owed_q.pop_front();
            if (got.status != want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.value_out != want.value_out)
                report($sformatf("value_out %h, want %h", got.value_out, want.value_out));
            if (got.position_out != want.position_out)
                report($sformatf("position_out %0d, want %0d",
                                 got.position_out, want.position_out));
            if (got.length_out != want.length_out)
                report($sformatf("length_out %0d, want %0d",
                                 got.length_out, want.length_out));
        end
    endtask
endclass

module tb_sequential_list_engine;
    import slc_pkg::*;

    localparam int RANDOM_ITEMS = 450;
    // worst case per item is roughly a long sender gap plus a long stall;
    // the limit leaves ample margin on top of that
    localparam int CYCLE_LIMIT  = 400000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    list_scoreboard      sb;
    logic [VAL_W-1:0]    value_pool [6];   // small pool so locate hits and duplicates occur
    bit                  no_gaps;          // set for bursts with back-to-back transactions
    int                  cycles    = 0;
    int                  ready_cnt = 0;

    sequential_list_engine uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // idle length: mostly zero or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // ready run length for the receiver: usually short, sometimes a long stretch
    function automatic int pick_run();
        if ($urandom_range(0, 99) < 15)
            return $urandom_range(20, 100);
        return $urandom_range(0, 5);
    endfunction

    // Receiver back-pressure: alternate stalls and ready runs of random length.
    // Only one nonblocking write to m_tready per edge.
    always @(posedge aclk) begin
        int stall;
        if (ready_cnt != 0) begin
            ready_cnt--;
        end else if (m_tready) begin
            stall = pick_gap();
            if (stall != 0) begin
                m_tready  <= 1'b0;
                ready_cnt = stall - 1;
            end else begin
                ready_cnt = pick_run();
            end
        end else begin
            m_tready  <= 1'b1;
            ready_cnt = pick_run();
        end
    end

    // result monitor: sample pre-edge values, so no race with the engine
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[sequential_list_engine] ERROR");
            $finish;
        end
    end

    // Present one input transaction and wait for the handshake. The shadow list
    // is updated right at acceptance so the next item can be built from it.
    // s_tvalid stays high into the next call unless that call idles first.
    task send_item(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {1'b0, val, pos, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, pos, val);
    endtask

    // Directed opening: empty-list cases, position zero and past the end,
    // inserts at front, middle and end, first-match locate, locate miss,
    // deletes at front, middle and end, all-zero and all-one values.
    task run_directed();
        send_item(OP_RETRIEVE, 5'd0,  32'h0);
        send_item(OP_RETRIEVE, 5'd1,  32'h0);
        send_item(OP_LOCATE,   5'd0,  32'h0);
        send_item(OP_DELETE,   5'd1,  32'h0);
        send_item(OP_INSERT,   5'd2,  32'h1111_1111);     // past end on empty list
        send_item(OP_INSERT,   5'd0,  32'h2222_2222);     // position zero
        send_item(OP_INSERT,   5'd31, 32'h3333_3333);
        send_item(OP_INSERT,   5'd1,  32'h0000_0000);
        send_item(OP_INSERT,   5'd2,  32'hFFFF_FFFF);     // append
        send_item(OP_INSERT,   5'd1,  32'h5A5A_5A5A);     // front
        send_item(OP_INSERT,   5'd3,  32'hA5A5_A5A5);     // middle
        send_item(OP_INSERT,   5'd5,  32'h0000_0000);     // duplicate at end
        send_item(OP_LOCATE,   5'd31, 32'h0000_0000);     // first of two matches
        send_item(OP_LOCATE,   5'd0,  32'hFFFF_FFFF);
        send_item(OP_LOCATE,   5'd1,  32'h1234_5678);     // miss
        send_item(OP_RETRIEVE, 5'd1,  32'hFFFF_FFFF);
        send_item(OP_RETRIEVE, 5'd5,  32'h0);
        send_item(OP_RETRIEVE, 5'd6,  32'h0);             // one past end
        send_item(OP_RETRIEVE, 5'd31, 32'h0);
        send_item(OP_DELETE,   5'd6,  32'h0);             // one past end
        send_item(OP_DELETE,   5'd0,  32'h0);
        send_item(OP_DELETE,   5'd3,  32'h0);             // middle
        send_item(OP_DELETE,   5'd1,  32'h0);             // front
        send_item(OP_DELETE,   5'd3,  32'h0);             // end
    endtask

    // Random part in bursts that lean toward growing, shrinking or a mix,
    // so the list swings between empty and full many times.
    task run_random();
        int               sent;
        int               burst;
        int               lean;
        int               r;
        int               len;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst   = $urandom_range(15, 40);
            lean    = $urandom_range(0, 2);           // 0 grow, 1 shrink, 2 mixed
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (burst) begin
                len = sb.length;
                r   = $urandom_range(0, 99);
                case (lean)
                    0:       op = (r < 60) ? OP_INSERT : (r < 70) ? OP_DELETE :
                                  (r < 85) ? OP_RETRIEVE : OP_LOCATE;
                    1:       op = (r < 60) ? OP_DELETE : (r < 70) ? OP_INSERT :
                                  (r < 85) ? OP_RETRIEVE : OP_LOCATE;
                    default: op = OP_W'($urandom_range(0, 3));
                endcase
                // positions mostly in or just past the valid range
                r = $urandom_range(0, 99);
                if (r < 85)
                    pos = POS_W'($urandom_range(1, len + 1));
                else if (r < 92)
                    pos = '0;
                else
                    pos = POS_W'($urandom_range(0, 31));
                r = $urandom_range(0, 99);
                if (op == OP_LOCATE && len > 0 && r < 60)
                    val = VAL_W'(sb.cells[$urandom_range(0, len - 1)]);
                else if (r < 80 && op != OP_RETRIEVE && op != OP_DELETE)
                    val = value_pool[$urandom_range(0, 5)];
                else
                    val = $urandom();
                send_item(op, pos, val);
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        int i;
        sb = new();
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (i = 2; i < 6; i++)
            value_pool[i] = $urandom();
        no_gaps = 1'b0;

        // synchronous reset, released before the first item
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        run_random();
        s_tvalid <= 1'b0;

        // drain: wait for every owed result, then keep watching for strays
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.owed_q.size() != 0)
            sb.report("results still outstanding at end of run");

        if (sb.errors == 0)
            $display("[sequential_list_engine] OK");
        else
            $display("[sequential_list_engine] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/slc_pkg.sv
hdl/slc_cell.sv
hdl/sequential_list_engine.sv
tb/tb_sequential_list_engine.sv
